[rtl/alu_branch_execute_unit_defines.svh]
// assertion macros used by the checker file
`ifndef ALU_BRANCH_EXECUTE_UNIT_DEFINES_SVH
`define ALU_BRANCH_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication
`define ABEU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abeu same-cycle check failed");

// next-cycle implication
`define ABEU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abeu next-cycle check failed");

`endif

[rtl/abeu_pkg.sv]
package abeu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 5;

  // opcodes of the execute stage
  typedef enum logic [4:0] {
    OP_MOV  = 5'd0,
    OP_ADD  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SWAP = 5'd3,
    OP_MUL  = 5'd4,
    OP_DIV  = 5'd5,
    OP_CMP  = 5'd6,
    OP_SHL  = 5'd7,
    OP_SHR  = 5'd8,
    OP_SAR  = 5'd9,
    OP_AND  = 5'd10,
    OP_OR   = 5'd11,
    OP_XOR  = 5'd12,
    OP_LDL  = 5'd13,
    OP_LDH  = 5'd14,
    OP_NOT  = 5'd15,
    OP_JMP  = 5'd16,
    OP_JZ   = 5'd17,
    OP_JP   = 5'd18,
    OP_JN   = 5'd19,
    OP_JNZ  = 5'd20,
    OP_JNP  = 5'd21,
    OP_JNN  = 5'd22,
    OP_STOP = 5'd23
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_BAD_OP   = 2'd2
  } err_t;

  // condition flag codes
  localparam logic [1:0] FLAG_ZERO = 2'b01;
  localparam logic [1:0] FLAG_NEG  = 2'b10;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } unit_req_t;

  // status back from the shared unit
  typedef struct packed {
    logic busy;
  } unit_stat_t;

  // one result beat
  typedef struct packed {
    logic [DataW-1:0] write_value;
    logic             write_first;
    logic [DataW-1:0] swap_value;
    logic             write_second;
    logic [DataW-1:0] remainder;
    logic             remainder_valid;
    logic             jump_taken;
    logic             halt;
    logic [1:0]       flags_out;
    err_t             error_code;
  } result_t;

  function automatic logic [1:0] flags_of(input logic [DataW-1:0] r);
    flags_of = {r[DataW-1], (r == '0)};
  endfunction

endpackage

[rtl/abeu_if.sv]
// request channel
interface abeu_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                output ready);
endinterface

// result channel
interface abeu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] write_value;
  logic               write_first;
  logic signed [31:0] swap_value;
  logic               write_second;
  logic signed [31:0] remainder;
  logic               remainder_valid;
  logic               jump_taken;
  logic               halt;
  logic [1:0]         flags_out;
  logic [1:0]         error_code;

  modport source (output valid, output write_value, output write_first,
                  output swap_value, output write_second, output remainder,
                  output remainder_valid, output jump_taken, output halt,
                  output flags_out, output error_code, input ready);
  modport sink (input valid, input write_value, input write_first,
                input swap_value, input write_second, input remainder,
                input remainder_valid, input jump_taken, input halt,
                input flags_out, input error_code, output ready);
endinterface

[rtl/abeu_iter_unit.sv]
module abeu_iter_unit (
  input  logic                clk,
  input  logic                rst,
  input  abeu_pkg::unit_req_t req,
  input  logic [31:0]         opa,
  input  logic [31:0]         opb,
  output abeu_pkg::unit_stat_t stat,
  output logic [31:0]         lo,
  output logic [31:0]         rem
);
  import abeu_pkg::*;

  logic              busy;
  logic              is_div;
  logic [CountW-1:0] count;
  logic [DataW-1:0]  acc;    // product or partial remainder
  logic [DataW-1:0]  q;      // multiplier or dividend/quotient
  logic [DataW-1:0]  d;      // multiplicand or divisor

  logic [DataW:0] add_x;
  logic [DataW:0] add_y;
  logic [DataW:0] sum;

  // shared adder: add for multiply, trial subtract for divide
  always_comb begin
    if (is_div) begin
      add_x = {acc, q[DataW-1]};
      add_y = ~{1'b0, d};
    end else begin
      add_x = {1'b0, acc};
      add_y = q[0] ? {1'b0, d} : '0;
    end
    sum = add_x + add_y + {{DataW{1'b0}}, is_div};
  end

  // one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy   <= 1'b1;
      count  <= '0;
      is_div <= req.is_div;
      acc    <= '0;
      q      <= opa;
      d      <= opb;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CountW'(DataW - 1)) begin
        busy <= 1'b0;
      end
      if (is_div) begin
        if (!sum[DataW]) begin
          acc <= sum[DataW-1:0];
          q   <= {q[DataW-2:0], 1'b1};
        end else begin
          acc <= {acc[DataW-2:0], q[DataW-1]};
          q   <= {q[DataW-2:0], 1'b0};
        end
      end else begin
        acc <= sum[DataW-1:0];
        q   <= {1'b0, q[DataW-1:1]};
        d   <= {d[DataW-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign lo        = is_div ? q : acc;
  assign rem       = acc;

endmodule

[rtl/alu_branch_execute_unit.sv]
// channel  dir  fields
// in_ch    in   req_type, operand_a, operand_b
// out_ch   out  write_value, write_first, swap_value, write_second, remainder,
//               remainder_valid, jump_taken, halt, flags_out, error_code
//
// simple ops, jumps and stop: result computed in S_EXEC and registered once the output slot is free
// mul and div (nonzero divisor): unit started in S_EXEC, result registered from S_WAIT once done
// (start, 32 iterations of one 33-bit adder in the shared unit, finish)
// a new beat is taken once the previous item has moved into the output register
// rst (synchronous) clears the flags, the sequencer and the output valid
// a stalled output holds the finished item in its execute state
module alu_branch_execute_unit (
  input  logic       clk,
  input  logic       rst,
  abeu_in_if.sink    in_ch,
  abeu_out_if.source out_ch
);
  import abeu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } state_t;

  state_t           state;
  opcode_t          op_r;
  logic [DataW-1:0] a_r;
  logic [DataW-1:0] b_r;
  logic [1:0]       cond_flags;
  logic             out_valid;
  result_t          out_r;

  unit_req_t        ureq;
  unit_stat_t       ustat;
  logic [DataW-1:0] u_lo;
  logic [DataW-1:0] u_rem;

  logic             needs_unit;
  logic             finish;
  logic             slot_free;
  logic             load_out;
  logic             set_flags;
  logic [DataW-1:0] alu_res;
  logic [DataW-1:0] mag_a;
  logic [DataW-1:0] mag_b;
  result_t          res;

  // operand magnitudes for signed division
  assign mag_a = a_r[DataW-1] ? (DataW'(0) - a_r) : a_r;
  assign mag_b = b_r[DataW-1] ? (DataW'(0) - b_r) : b_r;

  assign needs_unit = (op_r == OP_MUL) || ((op_r == OP_DIV) && (b_r != '0));
  assign slot_free  = !out_valid || out_ch.ready;
  assign finish     = ((state == S_EXEC) && !needs_unit) ||
                      ((state == S_WAIT) && !ustat.busy);
  assign load_out   = finish && slot_free;

  assign ureq = '{start: (state == S_EXEC) && needs_unit, is_div: (op_r == OP_DIV)};

  abeu_iter_unit u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .opa  ((op_r == OP_DIV) ? mag_a : a_r),
    .opb  ((op_r == OP_DIV) ? mag_b : b_r),
    .stat (ustat),
    .lo   (u_lo),
    .rem  (u_rem)
  );

  // result of the current item
  always_comb begin
    res        = '0;
    res.error_code = ERR_NONE;
    set_flags  = 1'b0;
    alu_res    = '0;
    case (op_r)
      OP_MOV: begin
        res.write_value = b_r;
        res.write_first = 1'b1;
      end
      OP_ADD: begin
        alu_res   = a_r + b_r;
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_SUB: begin
        alu_res   = a_r - b_r;
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_SWAP: begin
        res.write_value  = b_r;
        res.write_first  = 1'b1;
        res.swap_value   = a_r;
        res.write_second = 1'b1;
      end
      OP_MUL: begin
        alu_res   = u_lo;
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_DIV: begin
        if (b_r == '0) begin
          res.halt       = 1'b1;
          res.error_code = ERR_DIV_ZERO;
        end else begin
          alu_res   = (a_r[DataW-1] != b_r[DataW-1]) ? (DataW'(0) - u_lo) : u_lo;
          set_flags = 1'b1;
          res.write_value     = alu_res;
          res.write_first     = 1'b1;
          res.remainder       = a_r[DataW-1] ? (DataW'(0) - u_rem) : u_rem;
          res.remainder_valid = 1'b1;
        end
      end
      OP_CMP: begin
        alu_res   = a_r - b_r;
        set_flags = 1'b1;
      end
      OP_SHL: begin
        alu_res   = (b_r[DataW-1:CountW] != '0) ? '0 : (a_r << b_r[CountW-1:0]);
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_SHR: begin
        alu_res   = (b_r[DataW-1:CountW] != '0) ? '0 : (a_r >> b_r[CountW-1:0]);
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_SAR: begin
        alu_res   = (b_r[DataW-1:CountW] != '0) ? {DataW{a_r[DataW-1]}} :
                    DataW'($signed(a_r) >>> b_r[CountW-1:0]);
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_AND: begin
        alu_res   = a_r & b_r;
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_OR: begin
        alu_res   = a_r | b_r;
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_XOR: begin
        alu_res   = a_r ^ b_r;
        set_flags = 1'b1;
        res.write_value = alu_res;
        res.write_first = 1'b1;
      end
      OP_LDL: begin
        res.write_value = {a_r[DataW-1:16], b_r[15:0]};
        res.write_first = 1'b1;
      end
      OP_LDH: begin
        res.write_value = {b_r[15:0], a_r[15:0]};
        res.write_first = 1'b1;
      end
      OP_NOT: begin
        res.write_value = ~a_r;
        res.write_first = 1'b1;
      end
      OP_JMP: res.jump_taken = 1'b1;
      OP_JZ:  res.jump_taken = cond_flags[0];
      OP_JP:  res.jump_taken = (cond_flags == 2'b00);
      OP_JN:  res.jump_taken = cond_flags[1];
      OP_JNZ: res.jump_taken = !cond_flags[0];
      OP_JNP: res.jump_taken = (cond_flags == FLAG_NEG) || (cond_flags == FLAG_ZERO);
      OP_JNN: res.jump_taken = !cond_flags[1];
      OP_STOP: res.halt = 1'b1;
      default: res.error_code = ERR_BAD_OP;
    endcase
    res.flags_out = set_flags ? flags_of(alu_res) : cond_flags;
  end

  // sequencer, flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cond_flags <= '0;
      out_valid  <= 1'b0;
    end else begin
      // output valid: load a finished item, drop a taken beat
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r  <= opcode_t'(in_ch.req_type);
            a_r   <= in_ch.operand_a;
            b_r   <= in_ch.operand_b;
            state <= S_EXEC;
          end
        end
        S_EXEC, S_WAIT: begin
          if (ureq.start) begin
            state <= S_WAIT;
          end else if (load_out) begin
            out_r      <= res;
            cond_flags <= res.flags_out;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  assign out_ch.valid           = out_valid;
  assign out_ch.write_value     = out_r.write_value;
  assign out_ch.write_first     = out_r.write_first;
  assign out_ch.swap_value      = out_r.swap_value;
  assign out_ch.write_second    = out_r.write_second;
  assign out_ch.remainder       = out_r.remainder;
  assign out_ch.remainder_valid = out_r.remainder_valid;
  assign out_ch.jump_taken      = out_r.jump_taken;
  assign out_ch.halt            = out_r.halt;
  assign out_ch.flags_out       = out_r.flags_out;
  assign out_ch.error_code      = out_r.error_code;

endmodule

[rtl/abeu_checker.sv]
`include "alu_branch_execute_unit_defines.svh"

module abeu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] write_value,
  input logic        write_first,
  input logic        write_second,
  input logic        remainder_valid,
  input logic        halt,
  input logic [1:0]  error_code
);
  import abeu_pkg::*;

  // a waiting result beat stays up
  `ABEU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // one item at a time: no beat taken right after an accept
  `ABEU_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

  // division by zero halts and writes nothing
  `ABEU_ASSERT_NOW(a_div_zero, clk, rst, out_valid && (error_code == ERR_DIV_ZERO),
    halt && !write_first && !remainder_valid)

  // swap and remainder always come with a first-operand write
  `ABEU_ASSERT_NOW(a_second_write, clk, rst, out_valid && (write_second || remainder_valid),
    write_first)

  // unused write value reads zero
  `ABEU_ASSERT_NOW(a_wv_zero, clk, rst, out_valid && !write_first, write_value == '0)

endmodule

bind alu_branch_execute_unit abeu_checker u_abeu_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .write_value     (out_ch.write_value),
  .write_first     (out_ch.write_first),
  .write_second    (out_ch.write_second),
  .remainder_valid (out_ch.remainder_valid),
  .halt            (out_ch.halt),
  .error_code      (out_ch.error_code)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import abeu_pkg::*;

  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] LOW_HALF  = 32'h0000_FFFF;
  localparam logic [31:0] HIGH_HALF = 32'hFFFF_0000;
  localparam logic [31:0] MAX_POS   = 32'h7FFF_FFFF;
  localparam int RANDOM_ITEMS = 1800;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT = 16;

  // expected execute results plus the predicted condition flags
  class exec_board;
    logic [1:0] cond_flags;
    result_t expected_q[$];
    int unsigned mismatches;

    function new();
      cond_flags = 2'b00;
      mismatches = 0;
    endfunction

    function logic [1:0] flags_from(input logic [31:0] r);
      logic [1:0] f;
      f = 2'b00;
      if (r == 32'd0) f = f | FLAG_ZERO;
      if ((r & SIGN_BIT) != 0) f = f | FLAG_NEG;
      return f;
    endfunction

    // predict one instruction and update the kept flags
    function result_t execute_instr(input logic [4:0] op, input logic [31:0] a,
                                    input logic [31:0] b);
      result_t r;
      logic [31:0] res, ma, mb, mq, mr;
      logic set_flags, na, nb;
      r = '0;
      r.error_code = ERR_NONE;
      res = '0;
      set_flags = 1'b0;
      case (op)
        OP_MOV: begin
          r.write_value = b; r.write_first = 1'b1;
        end
        OP_ADD: begin
          res = a + b; set_flags = 1'b1;
        end
        OP_SUB: begin
          res = a - b; set_flags = 1'b1;
        end
        OP_SWAP: begin
          r.write_value = b; r.write_first = 1'b1;
          r.swap_value = a; r.write_second = 1'b1;
        end
        OP_MUL: begin
          res = a * b; set_flags = 1'b1;
        end
        OP_DIV: begin
          if (b == 32'd0) begin
            r.halt = 1'b1;
            r.error_code = ERR_DIV_ZERO;
          end else begin
            // work on magnitudes so the most negative dividend wraps cleanly
            na = a[31];
            nb = b[31];
            ma = na ? (32'd0 - a) : a;
            mb = nb ? (32'd0 - b) : b;
            mq = ma / mb;
            mr = ma % mb;
            res = (na != nb) ? (32'd0 - mq) : mq;
            r.remainder = na ? (32'd0 - mr) : mr;
            r.remainder_valid = 1'b1;
            set_flags = 1'b1;
          end
        end
        OP_CMP: begin
          res = a - b; set_flags = 1'b1;
        end
        OP_SHL: begin
          res = (b >= 32) ? 32'd0 : (a << b[4:0]); set_flags = 1'b1;
        end
        OP_SHR: begin
          res = (b >= 32) ? 32'd0 : (a >> b[4:0]); set_flags = 1'b1;
        end
        OP_SAR: begin
          // kept apart from unsigned operands so the shift stays arithmetic
          if (b >= 32) res = a[31] ? ALL_ONES : 32'd0;
          else res = $signed(a) >>> b[4:0];
          set_flags = 1'b1;
        end
        OP_AND: begin
          res = a & b; set_flags = 1'b1;
        end
        OP_OR: begin
          res = a | b; set_flags = 1'b1;
        end
        OP_XOR: begin
          res = a ^ b; set_flags = 1'b1;
        end
        OP_LDL: begin
          r.write_value = (b & LOW_HALF) | (a & HIGH_HALF); r.write_first = 1'b1;
        end
        OP_LDH: begin
          r.write_value = ((b << 16) & HIGH_HALF) | (a & LOW_HALF); r.write_first = 1'b1;
        end
        OP_NOT: begin
          r.write_value = ~a; r.write_first = 1'b1;
        end
        OP_JMP: r.jump_taken = 1'b1;
        OP_JZ:  r.jump_taken = (cond_flags & FLAG_ZERO) != 0;
        OP_JP:  r.jump_taken = (cond_flags == 2'b00);
        OP_JN:  r.jump_taken = (cond_flags & FLAG_NEG) != 0;
        OP_JNZ: r.jump_taken = (cond_flags & FLAG_ZERO) == 0;
        OP_JNP: r.jump_taken = (cond_flags == FLAG_NEG) || (cond_flags == FLAG_ZERO);
        OP_JNN: r.jump_taken = (cond_flags & FLAG_NEG) == 0;
        OP_STOP: r.halt = 1'b1;
        default: r.error_code = ERR_BAD_OP;
      endcase
      // flag-setting ops all write back except compare
      if (set_flags) begin
        cond_flags = flags_from(res);
        if (op != OP_CMP) begin
          r.write_value = res;
          r.write_first = 1'b1;
        end
      end
      r.flags_out = cond_flags;
      return r;
    endfunction

    function void note_instr(input logic [4:0] op, input logic [31:0] a,
                             input logic [31:0] b);
      expected_q.push_back(execute_instr(op, a, b));
    endfunction

    function void check_field(input string fname, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h, actual %h", fname, want, got);
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      check_field("write_value", got.write_value, want.write_value);
      check_field("write_first", got.write_first, want.write_first);
      check_field("swap_value", got.swap_value, want.swap_value);
      check_field("write_second", got.write_second, want.write_second);
      check_field("remainder", got.remainder, want.remainder);
      check_field("remainder_valid", got.remainder_valid, want.remainder_valid);
      check_field("jump_taken", got.jump_taken, want.jump_taken);
      check_field("halt", got.halt, want.halt);
      check_field("flags_out", got.flags_out, want.flags_out);
      check_field("error_code", got.error_code, want.error_code);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic idle_enable;

  abeu_in_if  in_ch ();
  abeu_out_if out_ch ();

  exec_board board = new();

  alu_branch_execute_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL alu_branch_execute_unit");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !(idle_enable && ($urandom_range(0, 99) < IDLE_PCT));
    end
  end

  // record accepted instructions
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      board.note_instr(in_ch.req_type, in_ch.operand_a, in_ch.operand_b);
  end

  // check accepted result beats
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.write_value     = out_ch.write_value;
      got.write_first     = out_ch.write_first;
      got.swap_value      = out_ch.swap_value;
      got.write_second    = out_ch.write_second;
      got.remainder       = out_ch.remainder;
      got.remainder_valid = out_ch.remainder_valid;
      got.jump_taken      = out_ch.jump_taken;
      got.halt            = out_ch.halt;
      got.flags_out       = out_ch.flags_out;
      got.error_code      = err_t'(out_ch.error_code);
      board.check_result(got);
    end
  end

  // one instruction beat, with random gaps ahead of it
  task automatic send_instr(input logic [4:0] op, input logic [31:0] a,
                            input logic [31:0] b);
    while (idle_enable && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold the request side until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return SIGN_BIT;
      2: return MAX_POS;
      3: return ALL_ONES;
      4: return 32'($signed($urandom_range(0, 32)) - 16);
      default: return $urandom;
    endcase
  endfunction

  // extremes, every opcode, jumps under each flag state
  task automatic run_directed();
    send_instr(OP_MOV, 32'd0, ALL_ONES);
    send_instr(OP_ADD, MAX_POS, 32'd1);
    send_instr(OP_JN, 32'd100, 32'd0);
    send_instr(OP_JNP, 32'd101, 32'd0);
    send_instr(OP_SUB, 32'd5, 32'd5);
    send_instr(OP_JZ, 32'd102, 32'd0);
    send_instr(OP_JNZ, 32'd103, 32'd0);
    send_instr(OP_JNP, 32'd104, 32'd0);
    send_instr(OP_CMP, 32'd7, 32'd3);
    send_instr(OP_JP, 32'd105, 32'd0);
    send_instr(OP_JNN, 32'd106, 32'd0);
    send_instr(OP_MUL, MAX_POS, MAX_POS);
    send_instr(OP_DIV, SIGN_BIT, ALL_ONES);
    send_instr(OP_DIV, 32'hFFFF_FFF9, 32'd2);
    send_instr(OP_DIV, 32'd1234, 32'd0);
    send_instr(OP_SHL, ALL_ONES, 32'd32);
    send_instr(OP_SHR, SIGN_BIT, 32'd31);
    send_instr(OP_SAR, SIGN_BIT, ALL_ONES);
    send_instr(OP_SAR, 32'hF000_0001, 32'd0);
    send_instr(OP_SAR, 32'hF000_0000, 32'd4);
    send_instr(OP_AND, ALL_ONES, 32'h0F0F_0F0F);
    send_instr(OP_OR, 32'd0, 32'd0);
    send_instr(OP_XOR, ALL_ONES, 32'h5555_AAAA);
    send_instr(OP_LDL, ALL_ONES, 32'h1234_5678);
    send_instr(OP_LDH, 32'h0000_ABCD, 32'hFFFF_9876);
    send_instr(OP_NOT, MAX_POS, 32'd0);
    send_instr(OP_SWAP, SIGN_BIT, MAX_POS);
    send_instr(OP_JMP, ALL_ONES, 32'd0);
    send_instr(OP_STOP, 32'd0, 32'd0);
    send_instr(5'd24, ALL_ONES, ALL_ONES);
    send_instr(5'd31, 32'd0, 32'd0);
  endtask

  task automatic run_random();
    logic [4:0] op;
    logic [31:0] a, b;
    int sel;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a long stretch with no gaps or stalls on either side
      idle_enable <= !(n >= 600 && n < 900);
      if (n == 1200) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 6) op = 5'($urandom_range(24, 31));
      else if (sel < 12) op = ($urandom_range(0, 1) != 0) ? OP_MUL : OP_DIV;
      else op = 5'($urandom_range(0, 23));
      a = pick_operand();
      b = pick_operand();
      // shift counts mostly near the word width
      if ((op == OP_SHL || op == OP_SHR || op == OP_SAR) && ($urandom_range(0, 9) < 7))
        b = 32'($urandom_range(0, 40));
      send_instr(op, a, b);
    end
  endtask

  initial begin
    int leftover;
    rst = 1'b1;
    idle_enable = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftover = board.expected_q.size();
    if (board.mismatches == 0 && leftover == 0) begin
      $display("PASS alu_branch_execute_unit");
    end else begin
      $display("FAIL alu_branch_execute_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/abeu_pkg.sv
rtl/abeu_if.sv
rtl/abeu_iter_unit.sv
rtl/alu_branch_execute_unit.sv
rtl/abeu_checker.sv
verif/tb_top.sv
